// ===== src/ip_fragment_interval_tracker_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the fragment interval tracker.
// Defining NO_ASSERTIONS turns every check into an empty statement.
// ---------------------------------------------------------------------------
`ifndef IP_FRAGMENT_INTERVAL_TRACKER_DEFINES_SVH
`define IP_FRAGMENT_INTERVAL_TRACKER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define IFT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ift check failed");
`define IFT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ift check failed");
`else
`define IFT_ASSERT_IMPL(label, clk, rst, ante, cons)
`define IFT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/ift_pkg.sv =====
// ---------------------------------------------------------------------------
// ift_pkg
// Types and constants shared by the fragment interval tracker modules.
// ---------------------------------------------------------------------------
package ift_pkg;

   localparam int unsigned POS_W = 17;
   localparam logic [16:0] MAX_TOTAL = 17'd65535;

   localparam logic [2:0] ST_PROGRESS = 3'd0;
   localparam logic [2:0] ST_COMPLETE = 3'd1;
   localparam logic [2:0] ST_INVALID  = 3'd2;
   localparam logic [2:0] ST_DONE     = 3'd3;
   localparam logic [2:0] ST_OVERSIZE = 3'd4;
   localparam logic [2:0] ST_FULL     = 3'd5;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_SEARCH,
      S_PREV,
      S_TRIM,
      S_COVER,
      S_SUB,
      S_HEAD,
      S_SHIFT,
      S_STORE,
      S_FINISH,
      S_OUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // capture the input item
      logic clear;       // context reset
      logic check;       // length checks and length update
      logic search_step; // advance search index
      logic prev_load;   // read preceding interval
      logic trim;        // trim start against preceding interval
      logic cover_step;  // advance cover index
      logic sub_step;    // subtract one removed interval
      logic head;        // head trim of next follower
      logic shift_step;  // move one tail entry
      logic store;       // write new interval
      logic finish;      // completion check
      logic [2:0] drop_status;
      logic drop;        // finish with a drop status
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_clear;
      logic is_finished;
      logic bad;         // length check failed
      logic empty;       // end <= start
      logic search_more;
      logic cover_more;
      logic sub_more;
      logic shift_more;
      logic full;
   } stat_type;

endpackage

// ===== src/ift_datapath.sv =====
// ---------------------------------------------------------------------------
// ift_datapath
// Interval table, length and byte counters, and the result register.
// ---------------------------------------------------------------------------
`include "ip_fragment_interval_tracker_defines.svh"
module ift_datapath #(
   parameter int unsigned MAX_INTERVALS = 16,
   parameter int unsigned IDX_W = 4,
   parameter int unsigned CNT_W = 5
) (
   input  logic            clock,
   input  logic            reset,
   input  ift_pkg::cmd_type cmd,
   output ift_pkg::stat_type stat,
   input  logic [36:0]     in_data,
   output logic [70:0]     out_data
);
   import ift_pkg::*;

   logic [POS_W-1:0] start_mem [MAX_INTERVALS];
   logic [POS_W-1:0] end_mem   [MAX_INTERVALS];

   logic [CNT_W-1:0] count_ff, count_in;
   logic [POS_W-1:0] total_ff, total_in;
   logic [POS_W-1:0] recv_ff, recv_in;
   logic             first_ff, first_in, last_ff, last_in, fin_ff, fin_in;

   logic             req_ff;
   logic [POS_W-1:0] off_ff, off_in, end_ff, end_in;
   logic             mf_ff;
   logic [5:0]       hdr_ff;
   logic [CNT_W-1:0] pos_ff, pos_in, j_ff, j_in, k_ff, k_in;
   logic [POS_W-1:0] pend_ff;
   logic [70:0]      out_ff, out_in;

   // Raw end, computed from the captured item.
   logic [POS_W-1:0] raw_end, rnd_end, chk_end;
   logic             bad_c;
   logic [CNT_W-1:0] removed, tail_last;
   logic [IDX_W-1:0] pos_i, j_i, k_i;
   // Header plus payload needs one bit more than a byte position.
   logic [POS_W:0]   len_sum;

   assign pos_i = pos_ff[IDX_W-1:0];
   assign j_i   = j_ff[IDX_W-1:0];
   assign k_i   = k_ff[IDX_W-1:0];
   assign removed = j_ff - pos_ff;
   assign len_sum = {12'd0, hdr_ff} + {1'b0, total_ff};

   always_comb begin
      raw_end = off_ff + end_ff;  // end_ff holds payload until CHECK
      rnd_end = {raw_end[POS_W-1:3], 3'b000};
      chk_end = mf_ff ? rnd_end : raw_end;
      if (!mf_ff) begin
         bad_c = (raw_end < total_ff) || (last_ff && raw_end != total_ff);
      end else begin
         bad_c = (rnd_end > total_ff) && last_ff;
      end
   end

   always_comb begin
      stat.is_clear    = req_ff;
      stat.is_finished = fin_ff;
      stat.bad         = bad_c;
      stat.empty       = end_ff <= off_ff;
      stat.search_more = (pos_ff < count_ff) && (start_mem[pos_i] < off_ff);
      stat.cover_more  = (j_ff < count_ff) && (start_mem[j_i] < end_ff)
                         && (end_mem[j_i] <= end_ff);
      stat.full        = (count_ff - removed + 1'b1) > CNT_W'(MAX_INTERVALS);
      stat.sub_more    = k_ff < j_ff;
      stat.shift_more  = (k_ff != CNT_W'(0));
   end

   // Number of entries that follow the covered run.
   assign tail_last = count_ff - j_ff;

   always_comb begin
      count_in = count_ff; total_in = total_ff; recv_in = recv_ff;
      first_in = first_ff; last_in = last_ff; fin_in = fin_ff;
      off_in = off_ff; end_in = end_ff; pos_in = pos_ff; j_in = j_ff; k_in = k_ff;
      out_in = out_ff;
      if (cmd.load) begin
         off_in = {1'b0, in_data[13:1], 3'b000};
         end_in = {1'b0, in_data[30:15]};
      end
      if (cmd.clear) begin
         count_in = '0; total_in = '0; recv_in = '0;
         first_in = 1'b0; last_in = 1'b0; fin_in = 1'b0;
         out_in = {17'd0, 17'd0, 17'd0, 17'd0, ST_PROGRESS};
      end
      if (cmd.check) begin
         end_in = chk_end;
         pos_in = '0;
         if (!mf_ff) begin
            last_in = 1'b1; total_in = raw_end;
         end else if (rnd_end > total_ff) begin
            total_in = rnd_end;
         end
      end
      if (cmd.search_step) pos_in = pos_ff + 1'b1;
      if (cmd.trim && pos_ff != '0 && pend_ff > off_ff) off_in = pend_ff;
      if (cmd.trim) j_in = pos_ff;
      if (cmd.cover_step) j_in = j_ff + 1'b1;
      if (cmd.prev_load) k_in = pos_ff;
      if (cmd.sub_step) begin
         recv_in = recv_ff - (end_mem[k_i] - start_mem[k_i]);
         k_in = k_ff + 1'b1;
      end
      if (cmd.head) begin
         if (j_ff < count_ff && start_mem[j_i] < end_ff)
            recv_in = recv_ff - (end_ff - start_mem[j_i]);
         k_in = tail_last;
      end
      if (cmd.shift_step) k_in = k_ff - 1'b1;
      if (cmd.store) begin
         count_in = count_ff - removed + 1'b1;
         recv_in = recv_ff + (end_ff - off_ff);
         if (off_ff == '0) first_in = 1'b1;
      end
      if (cmd.finish) begin
         out_in = {17'd0, recv_ff, end_ff, off_ff, ST_PROGRESS};
         if (first_ff && last_ff && recv_ff == total_ff) begin
            fin_in = 1'b1;
            if (len_sum > {1'b0, MAX_TOTAL}) begin
               out_in[2:0] = ST_OVERSIZE;
            end else begin
               out_in[2:0] = ST_COMPLETE;
               out_in[70:54] = len_sum[POS_W-1:0];
            end
         end
      end
      if (cmd.drop) out_in = {17'd0, recv_ff, 17'd0, 17'd0, cmd.drop_status};
   end

   // Table writes: head trim, tail move and the new entry. The tail moves top
   // down when it grows by one slot and bottom up when it closes a gap.
   logic [CNT_W-1:0] step_idx, src_idx, dst_idx;
   assign step_idx = (removed == '0) ? k_ff : (tail_last - k_ff + 1'b1);
   assign src_idx = j_ff + step_idx - 1'b1;
   assign dst_idx = pos_ff + step_idx;

   always_ff @(posedge clock) begin
      if (cmd.prev_load && pos_ff != '0)
         pend_ff <= end_mem[IDX_W'(pos_ff - 1'b1)];
      if (cmd.head && j_ff < count_ff && start_mem[j_i] < end_ff)
         start_mem[j_i] <= end_ff;
      if (cmd.shift_step && k_ff != '0) begin
         start_mem[dst_idx[IDX_W-1:0]] <= start_mem[src_idx[IDX_W-1:0]];
         end_mem[dst_idx[IDX_W-1:0]]   <= end_mem[src_idx[IDX_W-1:0]];
      end
      if (cmd.store) begin
         start_mem[pos_i] <= off_ff;
         end_mem[pos_i]   <= end_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= in_data[0];
         mf_ff  <= in_data[14];
         hdr_ff <= in_data[36:31];
      end
      off_ff <= off_in; end_ff <= end_in;
      pos_ff <= pos_in; j_ff <= j_in; k_ff <= k_in;
      out_ff <= out_in;
      if (reset) begin
         count_ff <= '0; total_ff <= '0; recv_ff <= '0;
         first_ff <= 1'b0; last_ff <= 1'b0; fin_ff <= 1'b0;
      end else begin
         count_ff <= count_in; total_ff <= total_in; recv_ff <= recv_in;
         first_ff <= first_in; last_ff <= last_in; fin_ff <= fin_in;
      end
   end

   assign out_data = out_ff;

   `IFT_ASSERT_IMPL(a_count_range, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_INTERVALS))
   `IFT_ASSERT_NEXT(a_store_grows, clock, reset, cmd.store, count_ff != '0)
   `IFT_ASSERT_NEXT(a_clear_zero, clock, reset, cmd.clear, recv_ff == '0 && !fin_ff)
endmodule

// ===== src/ift_ctrl.sv =====
// ---------------------------------------------------------------------------
// ift_ctrl
// Sequencer that walks the interval table for one fragment.
// ---------------------------------------------------------------------------
`include "ip_fragment_interval_tracker_defines.svh"
module ift_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   output logic              out_valid,
   input  logic              out_ready,
   output ift_pkg::cmd_type  cmd,
   input  ift_pkg::stat_type stat
);
   import ift_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (in_valid) state_in = S_CHECK;
         S_CHECK: begin
            if (stat.is_clear || stat.is_finished || stat.bad) state_in = S_OUT;
            else state_in = S_SEARCH;
         end
         S_SEARCH: begin
            // Empty check uses the end set by the length check.
            if (stat.empty) state_in = S_OUT;
            else if (!stat.search_more) state_in = S_PREV;
         end
         S_PREV:   state_in = S_TRIM;
         S_TRIM:   state_in = S_COVER;
         S_COVER: begin
            if (stat.empty) state_in = S_OUT;
            else if (!stat.cover_more) state_in = stat.full ? S_OUT : S_SUB;
         end
         S_SUB:    if (!stat.sub_more) state_in = S_HEAD;
         S_HEAD:   state_in = S_SHIFT;
         S_SHIFT:  if (!stat.shift_more) state_in = S_STORE;
         S_STORE:  state_in = S_FINISH;
         S_FINISH: state_in = S_OUT;
         S_OUT:    if (out_ready) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      in_ready = state_ff == S_IDLE;
      out_valid = state_ff == S_OUT;
      case (state_ff)
         S_IDLE: cmd.load = in_valid;
         S_CHECK: begin
            if (stat.is_clear) cmd.clear = 1'b1;
            else if (stat.is_finished) begin
               cmd.drop = 1'b1; cmd.drop_status = ST_DONE;
            end else if (stat.bad) begin
               cmd.drop = 1'b1; cmd.drop_status = ST_INVALID;
            end else cmd.check = 1'b1;
         end
         S_SEARCH: begin
            if (stat.empty) begin
               cmd.drop = 1'b1; cmd.drop_status = ST_INVALID;
            end else cmd.search_step = stat.search_more;
         end
         S_PREV: cmd.prev_load = 1'b1;
         S_TRIM: cmd.trim = 1'b1;
         S_COVER: begin
            if (stat.empty) begin
               cmd.drop = 1'b1; cmd.drop_status = ST_INVALID;
            end else if (stat.cover_more) cmd.cover_step = 1'b1;
            else if (stat.full) begin
               cmd.drop = 1'b1; cmd.drop_status = ST_FULL;
            end
         end
         S_SUB:    cmd.sub_step = stat.sub_more;
         S_HEAD:   cmd.head = 1'b1;
         S_SHIFT:  cmd.shift_step = stat.shift_more;
         S_STORE:  cmd.store = 1'b1;
         S_FINISH: cmd.finish = 1'b1;
         default:  cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   `IFT_ASSERT_IMPL(a_one_side, clock, reset, 1'b1, !(in_ready && out_valid))
   `IFT_ASSERT_NEXT(a_out_hold, clock, reset, out_valid && !out_ready, out_valid)
   `IFT_ASSERT_NEXT(a_accept_work, clock, reset, in_valid && in_ready, !in_ready)
endmodule

// ===== src/ip_fragment_interval_tracker.sv =====
// ---------------------------------------------------------------------------
// ip_fragment_interval_tracker
// Reassembly bookkeeping for one IPv4 datagram over an offset-sorted table.
// ---------------------------------------------------------------------------
// Channel  Ports                   Contents
// req      req_t{valid,ready,data,user}  one fragment or clear request per beat
// rsp      rsp_t{valid,ready,data}  one status beat per request beat
//
// A fragment's walk moves one table entry per cycle. Drops end earlier; a clear
// or an already complete datagram goes from the check straight to the result.
// Reset is synchronous and empties the context; table contents need no clear.
// The block holds one beat at a time; rsp stalls hold the result register.
// ---------------------------------------------------------------------------
module ip_fragment_interval_tracker #(
   parameter int unsigned MAX_INTERVALS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // offset_units, more_fragments, payload_bytes, header_bytes
   input  logic [39:0] req_tdata,
   // req_type
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status, kept_start, kept_end, bytes_held, total_length
   output logic [71:0] rsp_tdata
);
   import ift_pkg::*;

   localparam int unsigned IDX_W = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_INTERVALS + 1) + 1;

   cmd_type   cmd;
   stat_type  stat;
   logic [70:0] dp_out;

   ift_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .cmd(cmd), .stat(stat)
   );

   ift_datapath #(.MAX_INTERVALS(MAX_INTERVALS), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .in_data({req_tdata[35:0], req_tuser}), .out_data(dp_out)
   );

   assign rsp_tdata = {1'b0, dp_out};
endmodule

// ===== tb/ip_fragment_interval_tracker_tb.sv =====
// ---------------------------------------------------------------------------
// ip_fragment_interval_tracker_tb
// Drives fragment and clear beats into the tracker and checks every status
// beat field by field against a behavioral model of the reassembly table,
// under random stalls on both streams.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module ip_fragment_interval_tracker_tb;
   import ift_pkg::*;

   localparam int TABLE_DEPTH = 16;
   localparam int DRAIN_CYCLES = 60;

   typedef struct {
      logic [2:0]  status;
      logic [16:0] kept_start;
      logic [16:0] kept_end;
      logic [16:0] bytes_held;
      logic [16:0] total_length;
   } status_beat_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int error_count = 0;
   int beats_sent = 0;
   status_beat_t pending_status[$];

   // Model of the reassembly context.
   int frag_lo[TABLE_DEPTH];
   int frag_hi[TABLE_DEPTH];
   int frag_count = 0;
   int datagram_len = 0;
   int held_bytes = 0;
   bit got_first = 0;
   bit got_last = 0;
   bit done_flag = 0;

   ip_fragment_interval_tracker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   function automatic status_beat_t track_fragment(logic clr, logic [39:0] d);
      int off, fin, pay, hdr, pos, j, removed, newcount, total;
      int new_lo[TABLE_DEPTH];
      int new_hi[TABLE_DEPTH];
      bit mf;
      status_beat_t r;
      r = '{default: '0};
      if (clr) begin
         frag_count = 0; datagram_len = 0; held_bytes = 0;
         got_first = 0; got_last = 0; done_flag = 0;
         return r;
      end
      r.bytes_held = held_bytes[16:0];
      if (done_flag) begin
         r.status = ST_DONE;
         return r;
      end
      off = int'(d[12:0]) * 8;
      mf  = d[13];
      pay = int'(d[29:14]);
      hdr = int'(d[35:30]);
      fin = off + pay;
      r.status = ST_INVALID;
      if (!mf) begin
         if (fin < datagram_len || (got_last && fin != datagram_len)) return r;
         got_last = 1;
         datagram_len = fin;
      end else begin
         fin = fin & ~7;
         if (fin > datagram_len) begin
            if (got_last) return r;
            datagram_len = fin;
         end
      end
      if (fin <= off) return r;
      pos = 0;
      while (pos < frag_count && frag_lo[pos] < off) pos++;
      if (pos > 0 && frag_hi[pos-1] > off) begin
         off = frag_hi[pos-1];
         if (fin <= off) return r;
      end
      removed = 0;
      while (pos + removed < frag_count && frag_lo[pos+removed] < fin
             && frag_hi[pos+removed] <= fin) removed++;
      newcount = frag_count - removed + 1;
      if (newcount > TABLE_DEPTH) begin
         r.status = ST_FULL;
         return r;
      end
      for (j = pos; j < pos + removed; j++) held_bytes -= frag_hi[j] - frag_lo[j];
      j = pos + removed;
      if (j < frag_count && frag_lo[j] < fin) begin
         held_bytes -= fin - frag_lo[j];
         frag_lo[j] = fin;
      end
      for (j = 0; j < pos; j++) begin
         new_lo[j] = frag_lo[j]; new_hi[j] = frag_hi[j];
      end
      new_lo[pos] = off; new_hi[pos] = fin;
      for (j = pos + removed; j < frag_count; j++) begin
         new_lo[j - removed + 1] = frag_lo[j]; new_hi[j - removed + 1] = frag_hi[j];
      end
      frag_lo = new_lo; frag_hi = new_hi;
      frag_count = newcount;
      held_bytes = (held_bytes + fin - off) & 32'h1FFFF;
      if (off == 0) got_first = 1;
      r.kept_start = off[16:0];
      r.kept_end   = fin[16:0];
      r.bytes_held = held_bytes[16:0];
      r.status     = ST_PROGRESS;
      if (got_first && got_last && held_bytes == datagram_len) begin
         total = hdr + datagram_len;
         done_flag = 1;
         if (total > 65535) r.status = ST_OVERSIZE;
         else begin
            r.status = ST_COMPLETE;
            r.total_length = total[16:0];
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, field, got, want);
      error_count++;
   endtask

   // Sends one beat; valid stays high across back-to-back beats.
   task automatic send_beat(bit clr, int units, bit mf, int pay, int hdr);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= clr;
      req_tdata  <= {4'b0, 6'(hdr), 16'(pay), mf, 13'(units)};
      do @(posedge clock); while (!req_tready);
      pending_status.push_back(track_fragment(req_tuser, req_tdata));
      beats_sent++;
   endtask

   task automatic send_fragment(int units, bit mf, int pay, int hdr);
      send_beat(1'b0, units, mf, pay, hdr);
   endtask

   task automatic send_clear();
      send_beat(1'b1, $urandom_range(0, 8191), $urandom_range(0, 1),
                $urandom_range(0, 65535), $urandom_range(0, 63));
   endtask

   task automatic pause_until_drained();
      req_tvalid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      status_beat_t want;
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_status.size() == 0) begin
            $display("unexpected status beat at %0t", $time);
            error_count++;
         end else begin
            want = pending_status.pop_front();
            if (rsp_tdata[2:0] != want.status)
               report_mismatch("status", rsp_tdata[2:0], want.status);
            if (rsp_tdata[19:3] != want.kept_start)
               report_mismatch("kept_start", rsp_tdata[19:3], want.kept_start);
            if (rsp_tdata[36:20] != want.kept_end)
               report_mismatch("kept_end", rsp_tdata[36:20], want.kept_end);
            if (rsp_tdata[53:37] != want.bytes_held)
               report_mismatch("bytes_held", rsp_tdata[53:37], want.bytes_held);
            if (rsp_tdata[70:54] != want.total_length)
               report_mismatch("total_length", rsp_tdata[70:54], want.total_length);
         end
      end
   end

   task automatic test_special_cases();
      send_fragment(8191, 0, 65535, 63);   // farthest end, first byte missing
      send_clear();
      send_fragment(0, 0, 100, 20);        // whole datagram in one fragment
      send_fragment(0, 0, 100, 20);        // already complete
      send_clear();
      send_fragment(0, 0, 65535, 60);      // oversize total
      send_clear();
      send_fragment(10, 0, 8, 42);         // final fragment fixes length 88
      send_fragment(10, 0, 9, 21);         // final end differs
      send_fragment(1, 0, 7, 21);          // final end below known length
      send_fragment(10, 1, 16, 21);        // non-final past the end
      send_fragment(2, 1, 0, 21);          // empty
      send_fragment(2, 1, 7, 21);          // rounds down to empty
      send_fragment(0, 1, 40, 20);
      send_fragment(3, 1, 40, 20);         // start trimmed past predecessor
      send_fragment(1, 1, 16, 20);         // trimmed to nothing
      send_fragment(6, 1, 20, 20);         // trimmed to nothing
      send_fragment(0, 1, 88, 20);         // covers everything stored
      send_fragment(11, 0, 0, 0);          // already complete
      send_clear();
   endtask

   task automatic test_table_full();
      int k;
      pause_until_drained();
      for (k = 0; k < TABLE_DEPTH + 1; k++) send_fragment(2 * k + 1, 1, 8, 20);
      send_fragment(1, 1, 8 * 31, 20);     // replaces all stored entries at once
      send_fragment(0, 0, 8 * 40 + 5, 33);
      send_fragment(0, 1, 8, 33);
      send_clear();
   endtask

   // Well-formed datagrams split into shuffled, partly overlapping pieces, with stray random fragments.
   task automatic test_random_datagrams(int idle_pct, int stall_pct, int beat_budget);
      int stop_at, len_units, tail_bytes, a, b, k, n, idx;
      int cut_lo[$];
      int cut_hi[$];
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      stop_at = beats_sent + beat_budget;
      while (beats_sent < stop_at) begin
         send_clear();
         len_units = ($urandom_range(0, 19) == 0) ? $urandom_range(200, 8000)
                                                  : $urandom_range(1, 60);
         tail_bytes = $urandom_range(0, 8);
         cut_lo.delete(); cut_hi.delete();
         a = 0;
         while (a < len_units) begin
            b = (len_units > 100) ? len_units : a + $urandom_range(1, 8);
            if (b > len_units) b = len_units;
            cut_lo.push_back(a); cut_hi.push_back(b);
            a = b;
         end
         n = cut_lo.size();
         for (k = n - 1; k > 0; k--) begin
            idx = $urandom_range(0, k);
            a = cut_lo[k]; cut_lo[k] = cut_lo[idx]; cut_lo[idx] = a;
            b = cut_hi[k]; cut_hi[k] = cut_hi[idx]; cut_hi[idx] = b;
         end
         for (k = 0; k < n; k++) begin
            a = cut_lo[k];
            if (a > 0 && $urandom_range(0, 3) == 0) a = a - $urandom_range(1, a < 3 ? a : 3);
            if (cut_hi[k] == len_units)
               send_fragment(a, 0, (len_units - a) * 8 + tail_bytes, $urandom_range(20, 60));
            else
               send_fragment(a, 1, (cut_hi[k] - a) * 8 + $urandom_range(0, 7),
                             $urandom_range(20, 60));
            if ($urandom_range(0, 9) == 0)
               send_fragment($urandom_range(0, 8191), $urandom_range(0, 1),
                             $urandom_range(0, 65535), $urandom_range(0, 63));
         end
         if ($urandom_range(0, 3) == 0) send_fragment(0, 1, 8, 20);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_special_cases();
      test_table_full();
      test_random_datagrams(36, 76, 470);
      pause_until_drained();
      test_random_datagrams(76, 36, 470);
      test_random_datagrams(0, 0, 470);
      req_tvalid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #40ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
